// ===== hw/rtl/sus_pkg.sv =====
package sus_pkg;

  // Item kinds carried in s_tuser
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // Result codes carried in m_tuser
  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_READ_OK   = 3'd3,
    ST_BAD_RANK  = 3'd4
  } status_t;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CMP   = 3'b010,
    S_APPLY = 3'b100
  } state_t;

  // Control broadcast to every cell
  typedef struct packed {
    logic cmp_en;
    logic shift_en;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/sorted_unique_set_insert_top.sv =====
// Sorted unique set held in a chain of compare-and-shift cells.
// An accepted item passes through the compare and apply states before its result is registered.
// A new item is accepted only in idle, once the previous item's compare-then-shift sequence is done.
// A waiting result does not block the next accept; apply stalls only on a full output.
// Reset (rst, synchronous) empties the set and clears control; entries are not cleared.
module sorted_unique_set_insert_top #(
  parameter int CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [31:0] item_value, [36:32] rank, [39:37] zero
  input  logic        s_tuser,   // [0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] read_value, [37:32] entry_count, [39:38] zero
  output logic [2:0]  m_tuser    // [2:0] status
);
  import sus_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > 5) ? CW : 5;
  localparam int RN = (CAPACITY < 32) ? CAPACITY : 32;

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic kind_r;
  logic signed [31:0] value_r;
  logic [4:0] rank_r;

  cell_ctrl_t ctrl;
  logic signed [31:0] entries [CAPACITY];
  logic signed [31:0] prev_entries [CAPACITY];
  logic [CAPACITY-1:0] less, eq, occupied, prev_less;

  logic in_acc, out_free, do_apply, found, full, ins_ok, rank_ok;
  logic signed [31:0] rd_sel;
  logic [CW-1:0] count_after;
  logic [CW+5:0] count_wide;
  status_t status;
  logic signed [31:0] read_value;

  assign s_tready = (state == S_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign do_apply = (state == S_APPLY) && out_free;

  // Sequence each item through compare and apply
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_acc) state_next = S_CMP;
      S_CMP:   state_next = S_APPLY;
      S_APPLY: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r  <= s_tuser;
      value_r <= s_tdata[31:0];
      rank_r  <= s_tdata[36:32];
    end
  end

  // Decide the insert outcome from the registered cell flags
  assign found  = |eq;
  assign full   = (count == CW'(CAPACITY));
  assign ins_ok = (kind_r == KIND_INSERT) && !found && !full;

  assign ctrl.cmp_en   = (state == S_CMP);
  assign ctrl.shift_en = do_apply && ins_ok;

  // Build the cell chain
  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      assign occupied[i] = CW'(i) < count;
      if (i == 0) begin : g_head
        assign prev_less[i]    = 1'b1;
        assign prev_entries[i] = value_r;
      end else begin : g_body
        assign prev_less[i]    = less[i-1];
        assign prev_entries[i] = entries[i-1];
      end
      sus_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .occupied   (occupied[i]),
        .new_value  (value_r),
        .prev_less  (prev_less[i]),
        .prev_entry (prev_entries[i]),
        .entry      (entries[i]),
        .less       (less[i]),
        .eq         (eq[i])
      );
    end
  endgenerate

  // Advance the count on a successful insert
  assign count_next = ctrl.shift_en ? count + CW'(1) : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Select the entry at the requested rank
  always_comb begin
    rd_sel = '0;
    for (int k = 0; k < RN; k++) begin
      if (rank_r == 5'(k)) rd_sel = entries[k];
    end
  end

  assign rank_ok = XW'(rank_r) < XW'(count);

  // Form the result
  always_comb begin
    read_value = '0;
    if (kind_r == KIND_READ) begin
      if (rank_ok) begin
        status     = ST_READ_OK;
        read_value = rd_sel;
      end else begin
        status = ST_BAD_RANK;
      end
    end else if (found) begin
      status = ST_DUPLICATE;
    end else if (full) begin
      status = ST_FULL;
    end else begin
      status = ST_INSERTED;
    end
  end

  assign count_after = count_next;
  assign count_wide  = {6'b0, count_after};

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (do_apply) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_apply) begin
      m_tdata <= {2'b00, count_wide[5:0], read_value};
      m_tuser <= status;
    end
  end

endmodule

// ===== hw/rtl/sus_cell.sv =====
module sus_cell (
  input  logic                clk,
  input  sus_pkg::cell_ctrl_t ctrl,
  input  logic                occupied,
  input  logic signed [31:0]  new_value,
  input  logic                prev_less,
  input  logic signed [31:0]  prev_entry,
  output logic signed [31:0]  entry,
  output logic                less,
  output logic                eq
);
  import sus_pkg::*;

  // Compare the stored entry against the new value
  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      less <= occupied && (entry < new_value);
      eq   <= occupied && (entry == new_value);
    end
  end

  // Keep, take the new value, or take the left neighbor's entry
  always_ff @(posedge clk) begin
    if (ctrl.shift_en && !less) begin
      if (prev_less) begin
        entry <= new_value;
      end else begin
        entry <= prev_entry;
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import sus_pkg::*;

  localparam int SET_CAPACITY = 32;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES = 12;

  // Receiver stall patterns
  localparam int RX_OPEN = 0;
  localparam int RX_SPARSE_STALL = 1;
  localparam int RX_HEAVY_STALL = 2;
  localparam int RX_ALTERNATE = 3;

  typedef struct packed {
    status_t     status;
    logic [31:0] read_value;
    logic [5:0]  entry_count;
  } set_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        s_tuser = KIND_INSERT;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [2:0]  m_tuser;

  // Predicted contents of the set
  logic signed [31:0] set_entries [SET_CAPACITY];
  int                 set_count = 0;
  set_result_t        pending_results [$];

  int  error_count = 0;
  int  burst_left = 0;
  bit  allow_gaps = 1'b1;
  int  hold_requests = 0;
  int  hold_served = 0;
  int  hold_left = 0;
  int  rx_mode = RX_OPEN;
  int  rx_left = 0;
  bit  rx_toggle = 1'b0;

  sorted_unique_set_insert_top #(.CAPACITY(SET_CAPACITY)) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Update the predicted set for one accepted item and queue its result
  task automatic apply_set_item(input logic kind, input logic signed [31:0] value,
                                input logic [4:0] rank);
    set_result_t res;
    int          pos;
    bit          found;
    res.read_value = '0;
    if (kind == KIND_INSERT) begin
      pos = 0;
      found = 1'b0;
      for (int i = 0; i < set_count; i++) begin
        if (set_entries[i] == value) found = 1'b1;
        if (set_entries[i] < value) pos = i + 1;
      end
      if (found) begin
        res.status = ST_DUPLICATE;
      end else if (set_count >= SET_CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        for (int i = set_count; i > pos; i--) set_entries[i] = set_entries[i - 1];
        set_entries[pos] = value;
        set_count++;
        res.status = ST_INSERTED;
      end
    end else if (int'(rank) < set_count) begin
      res.read_value = set_entries[rank];
      res.status = ST_READ_OK;
    end else begin
      res.status = ST_BAD_RANK;
    end
    res.entry_count = set_count[5:0];
    pending_results.push_back(res);
  endtask

  function automatic bit in_set(input logic signed [31:0] value);
    for (int i = 0; i < set_count; i++)
      if (set_entries[i] == value) return 1'b1;
    return 1'b0;
  endfunction

  // Pick an insert value: random, next to a stored entry, an extreme, small, or stored
  function automatic logic [31:0] pick_insert_value();
    int          sel;
    logic [31:0] v;
    sel = $urandom_range(0, 9);
    v = $urandom;
    if (sel < 3 && set_count > 0) begin
      v = set_entries[$urandom_range(0, set_count - 1)];
      v = ($urandom_range(0, 1) == 1) ? v + 32'd1 : v - 32'd1;
    end else if (sel == 3) begin
      case ($urandom_range(0, 3))
        0: v = 32'h8000_0000;
        1: v = 32'h7fff_ffff;
        2: v = 32'h0000_0000;
        default: v = 32'hffff_ffff;
      endcase
    end else if (sel < 6) begin
      v = 32'($signed($urandom_range(0, 40)) - 20);
    end else if (sel == 6 && set_count > 0) begin
      v = set_entries[$urandom_range(0, set_count - 1)];
    end
    return v;
  endfunction

  // Offer one item, starting at a falling edge; return at the falling edge after accept
  task automatic send_item(input logic kind, input logic [31:0] value, input logic [4:0] rank);
    int gap;
    if (allow_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {3'b000, rank, value};
    forever begin
      @(posedge clk);
      if (s_tready) break;
    end
    apply_set_item(kind, value, rank);
    if (burst_left > 0) burst_left--;
    @(negedge clk);
  endtask

  task automatic send_read(input logic [4:0] rank);
    send_item(KIND_READ, $urandom, rank);
  endtask

  task automatic send_insert(input logic [31:0] value);
    send_item(KIND_INSERT, value, 5'($urandom));
  endtask

  // Empty set reads, extreme values, duplicates and reads past the count
  task automatic test_empty_and_extremes();
    send_read(5'd0);
    send_read(5'd31);
    send_insert(32'h7fff_ffff);
    send_insert(32'h8000_0000);
    send_insert(32'h0000_0000);
    send_insert(32'hffff_ffff);
    send_insert(32'h0000_0001);
    send_insert(32'h8000_0000);
    send_insert(32'h7fff_ffff);
    send_item(KIND_READ, 32'hffff_ffff, 5'd0);
    send_item(KIND_READ, 32'h0000_0000, 5'd1);
    send_read(5'd2);
    send_read(5'd3);
    send_read(5'd4);
    send_read(5'd5);
    send_read(5'd31);
    send_item(KIND_INSERT, 32'h4000_0000, 5'd31);
    send_item(KIND_INSERT, 32'hbfff_ffff, 5'd0);
  endtask

  // Grow the set slowly, mostly reads so that ranks past the count come up at every size
  task automatic test_sparse_growth(input int n_items);
    for (int n = 0; n < n_items; n++) begin
      if ($urandom_range(0, 13) == 0) send_insert(pick_insert_value());
      else send_read(5'($urandom));
    end
  endtask

  // Fill to capacity, then hit the full cases
  task automatic test_fill_to_capacity();
    logic [31:0] v;
    while (set_count < SET_CAPACITY) begin
      send_insert(pick_insert_value());
    end
    // Duplicate while full reports a duplicate, not full
    send_insert(set_entries[0]);
    send_insert(set_entries[SET_CAPACITY - 1]);
    send_insert(set_entries[SET_CAPACITY / 2]);
    // New value while full is dropped
    for (int k = 0; k < 3; k++) begin
      v = $urandom;
      while (in_set(v)) v = $urandom;
      send_insert(v);
    end
    send_read(5'd0);
    send_read(5'd31);
  endtask

  // Random mix on the full set
  task automatic test_full_random(input int n_items);
    int sel;
    for (int n = 0; n < n_items; n++) begin
      sel = $urandom_range(0, 3);
      if (sel < 2) send_read(5'($urandom));
      else if (sel == 2) send_insert(set_entries[$urandom_range(0, set_count - 1)]);
      else send_insert(pick_insert_value());
    end
  endtask

  // Hold the output off for a long stretch while items keep coming
  task automatic test_output_hold_off(input int n_items);
    allow_gaps = 1'b0;
    hold_requests++;
    for (int n = 0; n < n_items; n++) begin
      if ($urandom_range(0, 1) == 0) send_read(5'($urandom));
      else send_insert(pick_insert_value());
    end
    allow_gaps = 1'b1;
  endtask

  // Receiver: stall pattern of its own, plus a counted hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_requests != hold_served) begin
      m_tready <= 1'b0;
      hold_left <= HOLD_OFF_CYCLES - 1;
      hold_served <= hold_requests;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= $urandom_range(RX_OPEN, RX_ALTERNATE);
        rx_left <= $urandom_range(16, 96);
      end else begin
        rx_left <= rx_left - 1;
      end
      rx_toggle <= ~rx_toggle;
      case (rx_mode)
        RX_OPEN:         m_tready <= 1'b1;
        RX_SPARSE_STALL: m_tready <= ($urandom_range(0, 9) > 2);
        RX_HEAVY_STALL:  m_tready <= ($urandom_range(0, 3) == 0);
        default:         m_tready <= rx_toggle;
      endcase
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    set_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status %0d read_value %h entry_count %0d",
                 $time, m_tuser, m_tdata[31:0], m_tdata[37:32]);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (status_t'(m_tuser) !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, m_tuser);
          error_count++;
        end
        if (m_tdata[31:0] !== want.read_value) begin
          $display("%0t: read_value expected %h actual %h",
                   $time, want.read_value, m_tdata[31:0]);
          error_count++;
        end
        if (m_tdata[37:32] !== want.entry_count) begin
          $display("%0t: entry_count expected %0d actual %0d",
                   $time, want.entry_count, m_tdata[37:32]);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_empty_and_extremes();
    test_sparse_growth(450);
    test_fill_to_capacity();
    test_output_hold_off(40);
    test_full_random(860);
    s_tvalid <= 1'b0;
    // Drain, then allow the pipeline to settle
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #6_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/sus_pkg.sv
hw/rtl/sus_cell.sv
hw/rtl/sorted_unique_set_insert_top.sv
tb/tb_top.sv
